// File: rtl/wire_datagram_deframer_defines.svh
// Assertion macros for the deframer checker.
// Needs a clock and an active-low reset named at each use.
`ifndef WIRE_DATAGRAM_DEFRAMER_DEFINES_SVH
`define WIRE_DATAGRAM_DEFRAMER_DEFINES_SVH

// same-cycle implication
`define WDD_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("deframer check failed");

// next-cycle implication
`define WDD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("deframer check failed");

`endif

// File: rtl/wdd_pkg.sv
// Types, constants and field offsets for the datagram deframer.
// No dependencies; imported by every deframer module and the checker.
`default_nettype none
package wdd_pkg;

  localparam int HdrBytes  = 28;
  localparam int AssocLoAt = 2;
  localparam int AssocHiAt = 10;
  localparam int SeqAt     = 18;
  localparam int TimeAt    = 22;
  localparam int LenAt     = 26;

  localparam int CfgIdxW  = 2;
  localparam int CfgDataW = 16;

  localparam logic [7:0]  RstWireVersion = 8'd1;
  localparam logic [7:0]  RstMaxType     = 8'd3;
  localparam logic [15:0] RstMaxPayload  = 16'd1200;
  localparam logic [6:0]  RstHmacBytes   = 7'd32;

  // out_tdata layout
  localparam int PayloadLsb = 0;
  localparam int StatusLsb  = 8;
  localparam int TypeLsb    = 11;
  localparam int AssocHiLsb = 19;
  localparam int AssocLoLsb = 83;
  localparam int SeqLsb     = 147;
  localparam int TimeLsb    = 179;
  localparam int LenLsb     = 211;
  localparam int OutUsedW   = 227;
  localparam int OutDataW   = 232;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_WIRE_VERSION,
    CFG_MAX_TYPE,
    CFG_MAX_PAYLOAD,
    CFG_HMAC_BYTES
  } cfg_idx_t;

  typedef enum logic [2:0] {
    ST_OK,
    ST_TRUNCATED,
    ST_BAD_VERSION,
    ST_BAD_TYPE,
    ST_TOO_LARGE,
    ST_LEN_MISMATCH
  } status_t;

  typedef enum logic {
    KIND_PAYLOAD,
    KIND_SUMMARY
  } kind_t;

  typedef struct packed {
    logic [7:0]  wire_version;
    logic [7:0]  max_type;
    logic [15:0] max_payload;
    logic [6:0]  hmac_bytes;
  } cfg_t;

  typedef struct packed {
    logic [7:0]  version;
    logic [7:0]  ptype;
    logic [63:0] assoc_lo;
    logic [63:0] assoc_hi;
    logic [31:0] seq;
    logic [31:0] time_ms;
    logic [15:0] len;
  } hdr_t;

  typedef struct packed {
    kind_t       kind;
    logic [7:0]  payload_byte;
    status_t     status;
    logic [7:0]  ptype;
    logic [63:0] assoc_hi;
    logic [63:0] assoc_lo;
    logic [31:0] seq;
    logic [31:0] time_ms;
    logic [15:0] len;
  } res_t;

endpackage
`default_nettype wire

// File: rtl/wdd_capture.sv
// Byte position counter and header capture registers.
// Depends on wdd_pkg; presents the header including the byte now in process.
`default_nettype none
module wdd_capture import wdd_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        adv,
  input  wire logic [7:0]  byte_in,
  input  wire logic        last_in,
  output hdr_t             hdr_view,
  output logic [15:0]      pos
);

  hdr_t        hdr_r, hdr_nxt;
  logic [15:0] pos_r, pos_nxt;

  assign pos = pos_r;

  always_comb begin
    hdr_view = hdr_r;
    if (pos_r == 16'd0) begin
      hdr_view.version = byte_in;
    end
    if (pos_r == 16'd1) begin
      hdr_view.ptype = byte_in;
    end
    for (int i = 0; i < 8; i++) begin
      if (pos_r == 16'(AssocLoAt + i)) hdr_view.assoc_lo[8*i +: 8] = byte_in;
      if (pos_r == 16'(AssocHiAt + i)) hdr_view.assoc_hi[8*i +: 8] = byte_in;
    end
    for (int i = 0; i < 4; i++) begin
      if (pos_r == 16'(SeqAt + i))  hdr_view.seq[8*i +: 8]     = byte_in;
      if (pos_r == 16'(TimeAt + i)) hdr_view.time_ms[8*i +: 8] = byte_in;
    end
    for (int i = 0; i < 2; i++) begin
      if (pos_r == 16'(LenAt + i)) hdr_view.len[8*i +: 8] = byte_in;
    end
  end

  always_comb begin
    hdr_nxt = hdr_r;
    pos_nxt = pos_r;
    if (adv) begin
      if (last_in) begin
        hdr_nxt = '0;
        pos_nxt = '0;
      end else begin
        hdr_nxt = hdr_view;
        if (pos_r != 16'hFFFF) pos_nxt = pos_r + 16'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hdr_r <= '0;
      pos_r <= '0;
    end else begin
      hdr_r <= hdr_nxt;
      pos_r <= pos_nxt;
    end
  end

endmodule
`default_nettype wire

// File: rtl/wdd_judge.sv
// Status checks and result formation for one byte.
// Depends on wdd_pkg; purely combinational.
`default_nettype none
module wdd_judge import wdd_pkg::*; (
  input  wire hdr_t        hdr_view,
  input  wire logic [15:0] pos,
  input  wire logic [7:0]  byte_in,
  input  wire logic        last_in,
  input  wire cfg_t        cfg,
  output logic             res_valid,
  output res_t             res
);

  logic [16:0] size;
  logic [16:0] min_size;
  logic [17:0] want_size;
  logic [16:0] pay_end;
  logic        len_ok;
  logic        in_payload;
  status_t     status;

  assign size      = {1'b0, pos} + 17'd1;
  assign min_size  = 17'(HdrBytes) + {10'd0, cfg.hmac_bytes};
  assign want_size = {1'b0, min_size} + {2'd0, hdr_view.len};
  assign pay_end   = 17'(HdrBytes) + {1'b0, hdr_view.len};
  assign len_ok    = hdr_view.len <= cfg.max_payload;
  assign in_payload = ({1'b0, pos} >= 17'(HdrBytes)) && ({1'b0, pos} < pay_end) && len_ok;

  always_comb begin
    priority if (size < min_size)                  status = ST_TRUNCATED;
    else if (hdr_view.version != cfg.wire_version) status = ST_BAD_VERSION;
    else if (hdr_view.ptype > cfg.max_type)        status = ST_BAD_TYPE;
    else if (!len_ok)                              status = ST_TOO_LARGE;
    else if ({1'b0, size} != want_size)            status = ST_LEN_MISMATCH;
    else                                           status = ST_OK;
  end

  always_comb begin
    res = '0;
    res_valid = 1'b0;
    if (last_in) begin
      res_valid    = 1'b1;
      res.kind     = KIND_SUMMARY;
      res.status   = status;
      res.ptype    = hdr_view.ptype;
      res.assoc_hi = hdr_view.assoc_hi;
      res.assoc_lo = hdr_view.assoc_lo;
      res.seq      = hdr_view.seq;
      res.time_ms  = hdr_view.time_ms;
      res.len      = hdr_view.len;
    end else if (in_payload) begin
      res_valid        = 1'b1;
      res.kind         = KIND_PAYLOAD;
      res.payload_byte = byte_in;
    end
  end

endmodule
`default_nettype wire

// File: rtl/wire_datagram_deframer.sv
// Datagram deframer: byte stream in, payload bytes and one summary per datagram out.
// Each byte passes through the input register and then the result register.
// Accepts one byte per cycle while the output is not held back by out_tready.
// Bytes that cause no result (header, trailer) are consumed without output.
// Reset clears the position, captured header and both valid flags, and loads
// config defaults: version 1, max type 3, max payload 1200, trailer 32 bytes.
`default_nettype none
module wire_datagram_deframer import wdd_pkg::*; (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_tvalid,
  output logic                     in_tready,
  input  wire logic [7:0]          in_tdata,   // [7:0] data_byte
  input  wire logic                in_tlast,
  output logic                     out_tvalid,
  input  wire logic                out_tready,
  output logic [OutDataW-1:0]      out_tdata,  // payload_byte, status, packet_type,
                                               // assoc_high, assoc_low, sequence_res,
                                               // time_ms, payload_length, zero pad
  output logic                     out_tuser,  // [0] kind
  input  wire logic                cfg_valid,
  output logic                     cfg_ready,
  input  wire logic [CfgIdxW-1:0]  cfg_index,
  input  wire logic [CfgDataW-1:0] cfg_data
);

  cfg_t        cfg_r;
  logic        in_valid_r;
  logic [7:0]  in_byte_r;
  logic        in_last_r;
  logic        out_valid_r;
  res_t        out_res_r;
  logic        adv;
  hdr_t        hdr_view;
  logic [15:0] pos;
  logic        res_valid;
  res_t        res;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.wire_version <= RstWireVersion;
      cfg_r.max_type     <= RstMaxType;
      cfg_r.max_payload  <= RstMaxPayload;
      cfg_r.hmac_bytes   <= RstHmacBytes;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_WIRE_VERSION: cfg_r.wire_version <= cfg_data[7:0];
        CFG_MAX_TYPE:     cfg_r.max_type     <= cfg_data[7:0];
        CFG_MAX_PAYLOAD:  cfg_r.max_payload  <= cfg_data[15:0];
        CFG_HMAC_BYTES:   cfg_r.hmac_bytes   <= cfg_data[6:0];
        default:          cfg_r              <= cfg_r;
      endcase
    end
  end

  assign adv       = in_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !in_valid_r || adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tvalid && in_tready) begin
      in_valid_r <= 1'b1;
    end else if (adv) begin
      in_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      in_byte_r <= in_tdata;
      in_last_r <= in_tlast;
    end
  end

  wdd_capture u_capture (
    .clk      (clk),
    .rst_n    (rst_n),
    .adv      (adv),
    .byte_in  (in_byte_r),
    .last_in  (in_last_r),
    .hdr_view (hdr_view),
    .pos      (pos)
  );

  wdd_judge u_judge (
    .hdr_view  (hdr_view),
    .pos       (pos),
    .byte_in   (in_byte_r),
    .last_in   (in_last_r),
    .cfg       (cfg_r),
    .res_valid (res_valid),
    .res       (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= res_valid;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_res_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_res_r.kind;
  assign out_tdata  = {5'd0, out_res_r.len, out_res_r.time_ms, out_res_r.seq,
                       out_res_r.assoc_lo, out_res_r.assoc_hi, out_res_r.ptype,
                       out_res_r.status, out_res_r.payload_byte};

endmodule
`default_nettype wire

// File: rtl/wdd_checker.sv
// Port-level checks for the deframer, bound to the top level.
// Depends on wdd_pkg and wire_datagram_deframer_defines.svh.
`default_nettype none
`include "wire_datagram_deframer_defines.svh"
module wdd_checker import wdd_pkg::*; (
  input wire logic                clk,
  input wire logic                rst_n,
  input wire logic                out_tvalid,
  input wire logic                out_tready,
  input wire logic [OutDataW-1:0] out_tdata,
  input wire logic                out_tuser
);

  `WDD_ASSERT_NEXT(a_out_hold, clk, rst_n, out_tvalid && !out_tready, $stable(out_tdata) && $stable(out_tuser) && out_tvalid)
  `WDD_ASSERT_IMPLY(a_payload_clean, clk, rst_n, out_tvalid && out_tuser == KIND_PAYLOAD, out_tdata[OutDataW-1:StatusLsb] == '0)
  `WDD_ASSERT_IMPLY(a_summary_byte_zero, clk, rst_n, out_tvalid && out_tuser == KIND_SUMMARY, out_tdata[StatusLsb-1:PayloadLsb] == '0)
  `WDD_ASSERT_IMPLY(a_status_range, clk, rst_n, out_tvalid && out_tuser == KIND_SUMMARY, out_tdata[TypeLsb-1:StatusLsb] <= 3'(ST_LEN_MISMATCH))

endmodule

bind wire_datagram_deframer wdd_checker u_wdd_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);
`default_nettype wire
